// File: hdl/scu_pkg.sv
`default_nettype none
package scu_pkg;

  typedef enum logic [7:0] {
    OP_NOP      = 8'd0,
    OP_HALT     = 8'd1,
    OP_AND      = 8'd2,
    OP_OR       = 8'd3,
    OP_XOR      = 8'd4,
    OP_ADD      = 8'd5,
    OP_PUSH     = 8'd6,
    OP_PUSH_INC = 8'd7,
    OP_PUSH_IMM = 8'd8,
    OP_PUSH_ADR = 8'd9,
    OP_POP      = 8'd10,
    OP_POPA     = 8'd11,
    OP_POPI     = 8'd12,
    OP_DUP      = 8'd13,
    OP_OVER     = 8'd14,
    OP_DROP     = 8'd15,
    OP_JUMP     = 8'd16,
    OP_CMP      = 8'd17,
    OP_JZR      = 8'd18,
    OP_JOV      = 8'd19,
    OP_CALL     = 8'd20,
    OP_RET      = 8'd21,
    OP_RETI     = 8'd22,
    OP_SEI      = 8'd23,
    OP_CLI      = 8'd24
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HALTED   = 3'd1,
    ST_BAD_OP   = 3'd2,
    ST_DS_OVER  = 3'd3,
    ST_DS_UNDER = 3'd4,
    ST_RS_OVER  = 3'd5,
    ST_RS_UNDER = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    DS_HOLD    = 2'd0,
    DS_PUSH    = 2'd1,
    DS_POP     = 2'd2,
    DS_REPLACE = 2'd3
  } ds_op_t;

  typedef struct packed {
    ds_op_t     op;
    logic [7:0] value;
  } ds_cmd_t;

  typedef struct packed {
    logic empty;
    logic has_two;
    logic full;
  } ds_stat_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] value;
  } rs_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rs_stat_t;

endpackage
`default_nettype wire

// File: hdl/scu_ifs.sv
`default_nettype none
interface scu_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] opcode;
  logic [7:0] operand_byte;
  logic [7:0] mem_read_data;
  logic [7:0] irq_vector;

  modport source (output valid, kind, opcode, operand_byte, mem_read_data, irq_vector,
                  input ready);
  modport sink (input valid, kind, opcode, operand_byte, mem_read_data, irq_vector,
                output ready);
endinterface

interface scu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_ip;
  logic [7:0] addr_reg;
  logic       mem_write_en;
  logic [7:0] mem_write_addr;
  logic [7:0] mem_write_data;
  logic [2:0] status;
  logic       flag_zero;
  logic       flag_overflow;
  logic       halted;
  logic       irq_taken;
  logic [7:0] stack_top;

  modport source (output valid, next_ip, addr_reg, mem_write_en, mem_write_addr,
                  mem_write_data, status, flag_zero, flag_overflow, halted, irq_taken,
                  stack_top, input ready);
  modport sink (input valid, next_ip, addr_reg, mem_write_en, mem_write_addr,
                mem_write_data, status, flag_zero, flag_overflow, halted, irq_taken,
                stack_top, output ready);
endinterface
`default_nettype wire

// File: hdl/stack_cpu_core_8bit_unit.sv
`default_nettype none
// 8-bit stack processor core. Each req transaction carries one fetched instruction
// (opcode, following program byte, bus byte read at A) or an interrupt request, and
// yields exactly one rsp transaction with IP, A, the flags, the stack top and any
// memory write. One transaction is executed per clock cycle: the instruction is
// decoded and applied in the cycle it is accepted and the outcome lands in the rsp
// register, so req stays ready while that register is free or being drained. The
// top two data stack bytes live in registers and deeper entries in a RAM whose
// registered read is prefetched for the next instruction; the return stack is a RAM
// prefetched the same way. No clearing pass is needed after reset. Status codes:
// 0 ok, 1 halted, 2 unknown opcode, 3/4 data stack over/underflow, 5/6 return stack
// over/underflow; a failing instruction changes no state.
module stack_cpu_core_8bit_unit import scu_pkg::*; #(
  parameter int DATA_STACK_DEPTH   = 32,
  parameter int RETURN_STACK_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  scu_req_if.sink      req,
  scu_rsp_if.source    rsp
);

  logic       acc;
  logic [7:0] ip;
  logic [7:0] a_reg;
  logic [7:0] ira;
  logic       fz;
  logic       fo;
  logic       fh;
  logic       fi;

  logic [7:0] ip_next;
  logic [7:0] a_reg_next;
  logic [7:0] ira_next;
  logic       fz_next;
  logic       fo_next;
  logic       fh_next;
  logic       fi_next;
  status_t    st_next;
  logic       wen;
  logic [7:0] waddr;
  logic [7:0] wdata;
  logic       taken;
  logic [7:0] top_next;

  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] rs_top;
  ds_stat_t   ds_st;
  rs_stat_t   rs_st;
  ds_cmd_t    ds_cmd;
  ds_cmd_t    ds_cmd_g;
  rs_cmd_t    rs_cmd;
  rs_cmd_t    rs_cmd_g;

  logic       need1;
  logic       need2;
  logic       pushes;
  logic [8:0] sum;
  logic [7:0] alu;
  logic [7:0] push_val;

  assign acc       = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  assign sum = {1'b0, x} + {1'b0, y};

  always_comb begin
    need1    = 1'b0;
    need2    = 1'b0;
    pushes   = 1'b0;
    alu      = sum[7:0];
    push_val = req.mem_read_data;
    unique case (req.opcode) inside
      OP_AND:  begin need2 = 1'b1; alu = x & y; end
      OP_OR:   begin need2 = 1'b1; alu = x | y; end
      OP_XOR:  begin need2 = 1'b1; alu = x ^ y; end
      OP_ADD:  need2 = 1'b1;
      OP_CMP:  need2 = 1'b1;
      OP_PUSH, OP_PUSH_INC: pushes = 1'b1;
      OP_PUSH_IMM: begin pushes = 1'b1; push_val = req.operand_byte; end
      OP_PUSH_ADR: begin pushes = 1'b1; push_val = a_reg; end
      OP_DUP:  begin need1 = 1'b1; pushes = 1'b1; push_val = x; end
      OP_OVER: begin need2 = 1'b1; pushes = 1'b1; push_val = y; end
      OP_POP, OP_POPA, OP_POPI, OP_DROP: need1 = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ip_next    = ip;
    a_reg_next = a_reg;
    ira_next   = ira;
    fz_next    = fz;
    fo_next    = fo;
    fh_next    = fh;
    fi_next    = fi;
    st_next    = ST_OK;
    wen        = 1'b0;
    waddr      = 8'h00;
    wdata      = 8'h00;
    taken      = 1'b0;
    top_next   = ds_st.empty ? 8'h00 : x;
    ds_cmd     = '{op: DS_HOLD, value: 8'h00};
    rs_cmd     = '{push: 1'b0, pop: 1'b0, value: ip};
    if (fh) begin
      st_next = ST_HALTED;
    end else if (req.kind) begin
      if (fi) begin
        ira_next = ip;
        ip_next  = req.irq_vector;
        taken    = 1'b1;
      end
    end else if (req.opcode > OP_CLI) begin
      st_next = ST_BAD_OP;
    end else if ((need2 && !ds_st.has_two) || (need1 && ds_st.empty)) begin
      st_next = ST_DS_UNDER;
    end else if (pushes && ds_st.full) begin
      st_next = ST_DS_OVER;
    end else if ((req.opcode == OP_CALL) && rs_st.full) begin
      st_next = ST_RS_OVER;
    end else if ((req.opcode == OP_RET) && rs_st.empty) begin
      st_next = ST_RS_UNDER;
    end else begin
      ip_next = ip + 8'd1;
      unique case (req.opcode) inside
        OP_HALT: begin
          fh_next = 1'b1;
          ip_next = ip;
        end
        OP_AND, OP_OR, OP_XOR, OP_ADD: begin
          ds_cmd   = '{op: DS_REPLACE, value: alu};
          top_next = alu;
          fz_next  = (alu == 8'h00);
          fo_next  = (req.opcode == OP_ADD) && sum[8];
        end
        OP_PUSH, OP_PUSH_INC, OP_PUSH_IMM, OP_PUSH_ADR, OP_DUP, OP_OVER: begin
          ds_cmd   = '{op: DS_PUSH, value: push_val};
          top_next = push_val;
          fz_next  = (push_val == 8'h00);
          fo_next  = 1'b0;
          if (req.opcode == OP_PUSH_INC) begin
            a_reg_next = a_reg + 8'd1;
          end
          if (req.opcode == OP_PUSH_IMM) begin
            ip_next = ip + 8'd2;
          end
        end
        OP_POP, OP_POPI, OP_POPA, OP_DROP: begin
          ds_cmd   = '{op: DS_POP, value: 8'h00};
          top_next = ds_st.has_two ? y : 8'h00;
          if (req.opcode == OP_POPA) begin
            a_reg_next = x;
          end
          if ((req.opcode == OP_POP) || (req.opcode == OP_POPI)) begin
            wen   = 1'b1;
            waddr = a_reg;
            wdata = x;
          end
          if (req.opcode == OP_POPI) begin
            a_reg_next = a_reg + 8'd1;
          end
        end
        OP_JUMP: ip_next = req.operand_byte;
        OP_CMP:  fz_next = (x == y);
        OP_JZR:  ip_next = fz ? req.operand_byte : ip + 8'd2;
        OP_JOV:  ip_next = fo ? req.operand_byte : ip + 8'd2;
        OP_CALL: begin
          rs_cmd.push = 1'b1;
          ip_next     = req.operand_byte;
        end
        OP_RET: begin
          rs_cmd.pop = 1'b1;
          ip_next    = rs_top + 8'd2;
        end
        OP_RETI: ip_next = ira;
        OP_SEI:  fi_next = 1'b1;
        OP_CLI:  fi_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    ds_cmd_g = ds_cmd;
    rs_cmd_g = rs_cmd;
    if (!acc) begin
      ds_cmd_g.op   = DS_HOLD;
      rs_cmd_g.push = 1'b0;
      rs_cmd_g.pop  = 1'b0;
    end
  end

  scu_dstack #(.DEPTH(DATA_STACK_DEPTH)) u_dstack (
    .clk (clk),
    .rst (rst),
    .cmd (ds_cmd_g),
    .x   (x),
    .y   (y),
    .st  (ds_st)
  );

  scu_rstack #(.DEPTH(RETURN_STACK_DEPTH)) u_rstack (
    .clk (clk),
    .rst (rst),
    .cmd (rs_cmd_g),
    .top (rs_top),
    .st  (rs_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ip        <= 8'h00;
      a_reg     <= 8'h00;
      ira       <= 8'h00;
      fz        <= 1'b0;
      fo        <= 1'b0;
      fh        <= 1'b0;
      fi        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (acc) begin
        ip        <= ip_next;
        a_reg     <= a_reg_next;
        ira       <= ira_next;
        fz        <= fz_next;
        fo        <= fo_next;
        fh        <= fh_next;
        fi        <= fi_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.next_ip        <= ip_next;
      rsp.addr_reg       <= a_reg_next;
      rsp.mem_write_en   <= wen;
      rsp.mem_write_addr <= waddr;
      rsp.mem_write_data <= wdata;
      rsp.status         <= st_next;
      rsp.flag_zero      <= fz_next;
      rsp.flag_overflow  <= fo_next;
      rsp.halted         <= fh_next;
      rsp.irq_taken      <= taken;
      rsp.stack_top      <= top_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) fh |=> fh)
    else $error("halt flag cleared");
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.mem_write_en |-> (rsp.status == ST_OK) && !rsp.irq_taken)
    else $error("memory write on failed or interrupt transaction");
  a_fail_holds_ip: assert property (@(posedge clk) disable iff (rst)
    acc && (st_next != ST_OK) |=> ip == $past(ip) && a_reg == $past(a_reg))
    else $error("failed transaction changed state");
  a_masked_irq: assert property (@(posedge clk) disable iff (rst)
    acc && req.kind && !fi |=> ip == $past(ip) && !rsp.irq_taken)
    else $error("masked interrupt redirected IP");
`endif

endmodule
`default_nettype wire

// File: hdl/scu_ram.sv
`default_nettype none
module scu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/scu_dstack.sv
`default_nettype none
module scu_dstack import scu_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  ds_cmd_t    cmd,
  output logic [7:0] x,
  output logic [7:0] y,
  output ds_stat_t   st
);

  localparam int DW       = $clog2(DEPTH + 1);
  localparam int RAM_DEPTH = (DEPTH > 2) ? DEPTH - 2 : 1;
  localparam int AW       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [7:0]    t0;
  logic [7:0]    t1;
  logic [7:0]    ram_q;
  logic [7:0]    z;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          byp;
  logic [7:0]    byp_data;

  assign x  = t0;
  assign y  = t1;
  assign z  = byp ? byp_data : ram_q;

  assign st.empty   = (depth == '0);
  assign st.has_two = (depth >= DW'(2));
  assign st.full    = (depth == DW'(DEPTH));

  always_comb begin
    case (cmd.op)
      DS_PUSH:            depth_next = depth + DW'(1);
      DS_POP, DS_REPLACE: depth_next = depth - DW'(1);
      default:            depth_next = depth;
    endcase
  end

  // spill second entry below the cached pair; prefetch the third entry
  assign wr_en   = (cmd.op == DS_PUSH) && st.has_two;
  assign wr_addr = AW'(depth - DW'(2));
  assign rd_addr = AW'(depth_next - DW'(3));

  scu_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (t1),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      byp   <= 1'b0;
    end else begin
      depth <= depth_next;
      byp   <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= t1;
    case (cmd.op)
      DS_PUSH: begin
        t0 <= cmd.value;
        t1 <= t0;
      end
      DS_POP: begin
        t0 <= t1;
        t1 <= z;
      end
      DS_REPLACE: begin
        t0 <= cmd.value;
        t1 <= z;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/scu_rstack.sv
`default_nettype none
module scu_rstack import scu_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  rs_cmd_t    cmd,
  output logic [7:0] top,
  output rs_stat_t   st
);

  localparam int DW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [7:0]    ram_q;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          byp;
  logic [7:0]    byp_data;

  assign st.empty = (depth == '0);
  assign st.full  = (depth == DW'(DEPTH));
  assign top      = byp ? byp_data : ram_q;

  always_comb begin
    depth_next = depth;
    if (cmd.push) begin
      depth_next = depth + DW'(1);
    end else if (cmd.pop) begin
      depth_next = depth - DW'(1);
    end
  end

  assign wr_addr = AW'(depth);
  assign rd_addr = AW'(depth_next - DW'(1));

  scu_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata (cmd.value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      byp   <= 1'b0;
    end else begin
      depth <= depth_next;
      byp   <= cmd.push && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= cmd.value;
  end

endmodule
`default_nettype wire
